/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/sofdf_pkg.sv */
// ----------------------------------------------------------------------------
// sofdf_pkg
// Types and constants shared by the start/length/XOR frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sofdf_pkg;

    // Framing constants
    localparam logic [7:0]  SOF_BYTE      = 8'hFE;
    localparam logic [15:0] CMD_RESET     = 16'hB245;
    localparam logic [15:0] SRC_RESET     = 16'h0000;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 9;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXP_COMMAND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_SOURCE  = 1'd1;

    // Parser phases
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHECK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COMMAND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SOURCE  = 2'd3;

    // Configuration values seen by the parser
    typedef struct packed {
        logic [WORD_W-1:0] expected_command;
        logic [WORD_W-1:0] expected_source;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0]   frame_byte;
        logic [INDEX_W-1:0]  byte_index;
        logic                last;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   data_length;
    } result_t;

endpackage

`default_nettype wire

/* rtl/sofdf_ifs.sv */
// ----------------------------------------------------------------------------
// sofdf_ifs
// Valid/ready channel interfaces for received bytes, results and config.
// ----------------------------------------------------------------------------
`default_nettype none

interface sofdf_rx_if;
    logic                          valid;
    logic                          ready;
    logic [sofdf_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sofdf_frame_if;
    logic                            valid;
    logic                            ready;
    logic [sofdf_pkg::BYTE_W-1:0]    frame_byte;
    logic [sofdf_pkg::INDEX_W-1:0]   byte_index;
    logic                            last;
    logic [sofdf_pkg::STATUS_W-1:0]  frame_status;
    logic [sofdf_pkg::BYTE_W-1:0]    data_length;

    modport source (output valid, output frame_byte, output byte_index, output last,
                    output frame_status, output data_length, input ready);
    modport sink   (input valid, input frame_byte, input byte_index, input last,
                    input frame_status, input data_length, output ready);
endinterface

interface sofdf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sofdf_pkg::CFG_IDX_W-1:0] index;
    logic [sofdf_pkg::WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/sofdf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sofdf_cfg_regs
// Expected command and source address registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sofdf_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [sofdf_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [sofdf_pkg::WORD_W-1:0]    wr_data,
    output sofdf_pkg::cfg_t                      cfg_vals
);

    logic [sofdf_pkg::WORD_W-1:0] exp_cmd_reg;
    logic [sofdf_pkg::WORD_W-1:0] exp_src_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_cmd_reg <= sofdf_pkg::CMD_RESET;
            exp_src_reg <= sofdf_pkg::SRC_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sofdf_pkg::REG_EXP_COMMAND: exp_cmd_reg <= wr_data;
                sofdf_pkg::REG_EXP_SOURCE:  exp_src_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg_vals.expected_command = exp_cmd_reg;
    assign cfg_vals.expected_source  = exp_src_reg;

endmodule

`default_nettype wire

/* rtl/sofdf_in_reg.sv */
// ----------------------------------------------------------------------------
// sofdf_in_reg
// Input register stage for received bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sofdf_in_reg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [sofdf_pkg::BYTE_W-1:0] in_byte,
    output logic                              in_ready,
    input  wire logic                         take,
    output logic                              held_valid,
    output logic [sofdf_pkg::BYTE_W-1:0]      held_byte
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [sofdf_pkg::BYTE_W-1:0] byte_reg;

    // Accept when empty or when the held word leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

/* rtl/sofdf_parser.sv */
// ----------------------------------------------------------------------------
// sofdf_parser
// Frame state machine, XOR check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sofdf_parser (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    input  wire logic [sofdf_pkg::BYTE_W-1:0] item_byte,
    output logic                              take,
    input  wire sofdf_pkg::cfg_t              cfg_vals,
    output logic                              res_valid,
    output sofdf_pkg::result_t                res,
    input  wire logic                         res_ready
);

    logic [1:0]                      phase_reg,  phase_next;
    logic [sofdf_pkg::BYTE_W-1:0]    len_reg,    len_next;
    logic [sofdf_pkg::INDEX_W-1:0]   remain_reg, remain_next;
    logic [sofdf_pkg::INDEX_W-1:0]   pos_reg,    pos_next;
    logic [sofdf_pkg::BYTE_W-1:0]    xor_reg,    xor_next;
    logic [sofdf_pkg::WORD_W-1:0]    cmd_reg,    cmd_next;
    logic [sofdf_pkg::WORD_W-1:0]    src_reg,    src_next;
    logic                            res_valid_reg, res_valid_next;
    sofdf_pkg::result_t              res_reg;
    sofdf_pkg::result_t              res_next;
    logic                            produce;
    logic [sofdf_pkg::STATUS_W-1:0]  status;

    // Advance when a byte waits and the result slot is free or drains this cycle
    assign take = item_valid && (!res_valid_reg || res_ready);

    // Status priority: check, then command, then source
    always_comb
    begin
        if (item_byte != xor_reg)
            status = sofdf_pkg::ST_CHECK;
        else if (cmd_reg != cfg_vals.expected_command)
            status = sofdf_pkg::ST_COMMAND;
        else if (len_reg < 8'd2 || src_reg != cfg_vals.expected_source)
            status = sofdf_pkg::ST_SOURCE;
        else
            status = sofdf_pkg::ST_ACCEPT;
    end

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        cmd_next    = cmd_reg;
        src_next    = src_reg;
        produce     = 1'b0;
        res_next.frame_byte   = item_byte;
        res_next.byte_index   = pos_reg;
        res_next.last         = 1'b0;
        res_next.frame_status = sofdf_pkg::ST_ACCEPT;
        res_next.data_length  = len_reg;

        case (phase_reg)
            sofdf_pkg::PH_LEN:
            begin
                len_next    = item_byte;
                remain_next = {1'b0, item_byte} + 9'd3;
                pos_next    = '0;
                xor_next    = item_byte;
                cmd_next    = '0;
                src_next    = '0;
                phase_next  = sofdf_pkg::PH_BODY;
            end
            sofdf_pkg::PH_BODY:
            begin
                produce = 1'b1;
                if (remain_reg <= 9'd1)
                begin
                    // Check byte closes the frame
                    res_next.last         = 1'b1;
                    res_next.frame_status = status;
                    remain_next           = '0;
                    phase_next            = sofdf_pkg::PH_HUNT;
                end
                else
                begin
                    xor_next = xor_reg ^ item_byte;
                    case (pos_reg)
                        9'd0:    cmd_next = {cmd_reg[15:8], item_byte};
                        9'd1:    cmd_next = {item_byte, cmd_reg[7:0]};
                        9'd2:    src_next = {src_reg[15:8], item_byte};
                        9'd3:    src_next = {item_byte, src_reg[7:0]};
                        default: ;
                    endcase
                    pos_next    = pos_reg + 9'd1;
                    remain_next = remain_reg - 9'd1;
                end
            end
            default:
            begin
                // Hunt for the start byte, drop everything else
                phase_next = (item_byte == sofdf_pkg::SOF_BYTE) ?
                             sofdf_pkg::PH_LEN : sofdf_pkg::PH_HUNT;
            end
        endcase
    end

    // Result slot: fill on a producing byte, drain on ready
    assign res_valid_next = take ? produce : (res_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sofdf_pkg::PH_HUNT;
            len_reg       <= '0;
            remain_reg    <= '0;
            pos_reg       <= '0;
            xor_reg       <= '0;
            cmd_reg       <= '0;
            src_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                len_reg    <= len_next;
                remain_reg <= remain_next;
                pos_reg    <= pos_next;
                xor_reg    <= xor_next;
                cmd_reg    <= cmd_next;
                src_reg    <= src_next;
            end
        end
    end

    // Hold payload until the next producing byte
    always_ff @(posedge clk)
    begin
        if (take && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* rtl/sof_length_xor_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// sof_length_xor_frame_deframer_top
// Start-of-frame / length / XOR check deframer for a serial byte stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle, without gaps, while the result
// channel is ready. A byte passes an input register and then the frame state
// machine, which updates and loads the result register; back-pressure holds
// the byte in the input register. Start and length bytes and bytes seen while
// hunting produce no word. Each command, data and check byte leaves with its
// index; the check byte carries last and the frame status. Configuration
// writes are taken every cycle and must only occur while idle.
`default_nettype none

module sof_length_xor_frame_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sofdf_rx_if.sink         rx,
    sofdf_frame_if.source    frame,
    sofdf_cfg_if.sink        cfg
);

    sofdf_pkg::cfg_t              cfg_vals;
    sofdf_pkg::result_t           res;
    logic                         take;
    logic                         held_valid;
    logic [sofdf_pkg::BYTE_W-1:0] held_byte;
    logic                         res_valid;

    // Config writes never stall
    assign cfg.ready = 1'b1;

    sofdf_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg_vals (cfg_vals)
    );

    sofdf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .in_ready   (rx.ready),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sofdf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (held_valid),
        .item_byte  (held_byte),
        .take       (take),
        .cfg_vals   (cfg_vals),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (frame.ready)
    );

    // Drive the result channel
    assign frame.valid        = res_valid;
    assign frame.frame_byte   = res.frame_byte;
    assign frame.byte_index   = res.byte_index;
    assign frame.last         = res.last;
    assign frame.frame_status = res.frame_status;
    assign frame.data_length  = res.data_length;

endmodule

`default_nettype wire

/* rtl/sofdf_checker.sv */
// ----------------------------------------------------------------------------
// sofdf_checker
// Port-level assertions for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sofdf_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [sofdf_pkg::BYTE_W-1:0]   out_byte,
    input wire logic [sofdf_pkg::INDEX_W-1:0]  out_index,
    input wire logic                           out_last,
    input wire logic [sofdf_pkg::STATUS_W-1:0] out_status,
    input wire logic [sofdf_pkg::BYTE_W-1:0]   out_length
);

    // Status is zero except on the check byte
    `ASSERT_SAME(a_status_only_last, clk, rst_n, out_valid && !out_last,
                 out_status == sofdf_pkg::ST_ACCEPT)

    // Check byte sits right after the data
    `ASSERT_SAME(a_last_index, clk, rst_n, out_valid && out_last,
                 out_index == ({1'b0, out_length} + 9'd2))

    // Body bytes stay inside the frame
    `ASSERT_SAME(a_body_index, clk, rst_n, out_valid && !out_last,
                 out_index <= ({1'b0, out_length} + 9'd1))

    // Stalled word holds
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(out_byte) && $stable(out_index) && $stable(out_last))

endmodule

bind sof_length_xor_frame_deframer_top sofdf_checker u_sofdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (frame.valid),
    .out_ready  (frame.ready),
    .out_byte   (frame.frame_byte),
    .out_index  (frame.byte_index),
    .out_last   (frame.last),
    .out_status (frame.frame_status),
    .out_length (frame.data_length)
);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the start/length/XOR frame deframer against a cycle-free predictor.
// Received bytes go in over the rx channel with random gaps, result words are
// taken with random back-pressure, and each word is matched field by field
// against the oldest predicted word. A short directed run comes first, then
// random frames (good and corrupted), noise and broken frames under four
// settings of the expected command and source registers.
// ----------------------------------------------------------------------------
`default_nettype none

// Predicts the deframer output for each accepted byte and checks the words.
class frame_scoreboard;
    logic [sofdf_pkg::WORD_W-1:0]  want_command;
    logic [sofdf_pkg::WORD_W-1:0]  want_source;
    logic [1:0]                    phase;
    logic [sofdf_pkg::BYTE_W-1:0]  frame_len;
    logic [sofdf_pkg::INDEX_W-1:0] left_count;
    logic [sofdf_pkg::INDEX_W-1:0] position;
    logic [sofdf_pkg::BYTE_W-1:0]  xor_acc;
    logic [sofdf_pkg::WORD_W-1:0]  command_seen;
    logic [sofdf_pkg::WORD_W-1:0]  source_seen;
    sofdf_pkg::result_t            expected_words[$];
    int                            errors;
    int                            words_checked;
    int                            status_count[4];

    function new();
        want_command = sofdf_pkg::CMD_RESET;
        want_source  = sofdf_pkg::SRC_RESET;
        phase        = sofdf_pkg::PH_HUNT;
        frame_len    = '0;
        left_count   = '0;
        position     = '0;
        xor_acc      = '0;
        command_seen = '0;
        source_seen  = '0;
        errors       = 0;
        words_checked = 0;
        foreach (status_count[i])
            status_count[i] = 0;
    endfunction

    function void write_reg(logic [sofdf_pkg::CFG_IDX_W-1:0] idx,
                            logic [sofdf_pkg::WORD_W-1:0] value);
        if (idx == sofdf_pkg::REG_EXP_COMMAND)
            want_command = value;
        else if (idx == sofdf_pkg::REG_EXP_SOURCE)
            want_source = value;
    endfunction

    // Advance the frame state by one received byte; queue a word if one is due
    function void note_byte(logic [sofdf_pkg::BYTE_W-1:0] b);
        sofdf_pkg::result_t w;
        if (phase == sofdf_pkg::PH_LEN)
        begin
            frame_len    = b;
            left_count   = {1'b0, b} + 9'd3;
            position     = '0;
            xor_acc      = b;
            command_seen = '0;
            source_seen  = '0;
            phase        = sofdf_pkg::PH_BODY;
            return;
        end
        if (phase != sofdf_pkg::PH_BODY)
        begin
            phase = (b == sofdf_pkg::SOF_BYTE) ? sofdf_pkg::PH_LEN : sofdf_pkg::PH_HUNT;
            return;
        end
        w.frame_byte  = b;
        w.byte_index  = position;
        w.data_length = frame_len;
        if (left_count <= 9'd1)
        begin
            // Check byte: priority is check, command, then source
            if (b != xor_acc)
                w.frame_status = sofdf_pkg::ST_CHECK;
            else if (command_seen != want_command)
                w.frame_status = sofdf_pkg::ST_COMMAND;
            else if (frame_len < 8'd2 || source_seen != want_source)
                w.frame_status = sofdf_pkg::ST_SOURCE;
            else
                w.frame_status = sofdf_pkg::ST_ACCEPT;
            w.last     = 1'b1;
            left_count = '0;
            phase      = sofdf_pkg::PH_HUNT;
        end
        else
        begin
            xor_acc = xor_acc ^ b;
            case (position)
                9'd0: command_seen[7:0]  = b;
                9'd1: command_seen[15:8] = b;
                9'd2: source_seen[7:0]   = b;
                9'd3: source_seen[15:8]  = b;
                default: ;
            endcase
            w.last         = 1'b0;
            w.frame_status = sofdf_pkg::ST_ACCEPT;
            position       = position + 9'd1;
            left_count     = left_count - 9'd1;
        end
        expected_words.push_back(w);
    endfunction

    function void check_word(sofdf_pkg::result_t got);
        sofdf_pkg::result_t want;
        if (expected_words.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word byte=%h idx=%0d last=%b status=%0d len=%0d",
                     $time, got.frame_byte, got.byte_index, got.last,
                     got.frame_status, got.data_length);
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        if (got.last)
            status_count[got.frame_status]++;
        if (got !== want)
        begin
            errors++;
            $display("%0t: mismatch expected byte=%h idx=%0d last=%b status=%0d len=%0d",
                     $time, want.frame_byte, want.byte_index, want.last,
                     want.frame_status, want.data_length);
            $display("%0t:            actual byte=%h idx=%0d last=%b status=%0d len=%0d",
                     $time, got.frame_byte, got.byte_index, got.last,
                     got.frame_status, got.data_length);
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module testbench;

    localparam int BYTE_TARGET = 1200;
    localparam int SETTLE_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n;

    sofdf_rx_if    rx_ch();
    sofdf_frame_if frame_ch();
    sofdf_cfg_if   cfg_ch();

    sof_length_xor_frame_deframer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    frame_scoreboard              sb;
    sofdf_pkg::result_t           seen_word;
    logic [sofdf_pkg::WORD_W-1:0] cur_command;
    logic [sofdf_pkg::WORD_W-1:0] cur_source;
    bit                           quiet;
    int                           rx_count;
    int                           frame_bytes;

    // Clock: period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones; none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Drive result back-pressure
    always
    begin
        int n;
        @(negedge clk);
        n = pick_gap();
        if (n == 0)
            frame_ch.ready <= 1'b1;
        else
        begin
            frame_ch.ready <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    end

    // Sample every handshake at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                seen_word.frame_byte   = frame_ch.frame_byte;
                seen_word.byte_index   = frame_ch.byte_index;
                seen_word.last         = frame_ch.last;
                seen_word.frame_status = frame_ch.frame_status;
                seen_word.data_length  = frame_ch.data_length;
                sb.check_word(seen_word);
            end
            if (rx_ch.valid && rx_ch.ready)
            begin
                sb.note_byte(rx_ch.rx_byte);
                rx_count++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // Offer one byte and hold it until it is taken
    task automatic send_byte(input logic [sofdf_pkg::BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
    endtask

    // Build and send one frame, optionally corrupting check, command or source
    task automatic send_frame(input int len, input bit bad_check, input bit bad_cmd,
                              input bit bad_src);
        logic [sofdf_pkg::WORD_W-1:0] cmd;
        logic [sofdf_pkg::WORD_W-1:0] src;
        logic [sofdf_pkg::BYTE_W-1:0] chk;
        logic [sofdf_pkg::BYTE_W-1:0] body[$];
        cmd = cur_command;
        src = cur_source;
        if (bad_cmd)
            cmd = cmd ^ 16'($urandom_range(1, 65535));
        if (bad_src)
            src = src ^ 16'($urandom_range(1, 65535));
        body.push_back(cmd[7:0]);
        body.push_back(cmd[15:8]);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                body.push_back(src[7:0]);
            else if (i == 1)
                body.push_back(src[15:8]);
            else
                body.push_back(8'($urandom_range(0, 255)));
        end
        chk = 8'(len);
        foreach (body[i])
            chk = chk ^ body[i];
        if (bad_check)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(sofdf_pkg::SOF_BYTE);
        send_byte(8'(len));
        foreach (body[i])
            send_byte(body[i]);
        send_byte(chk);
        frame_bytes += len + 5;
    endtask

    // Stop sending and wait out every pending word plus the pipeline
    task automatic drain();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sofdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sofdf_pkg::WORD_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (idx == sofdf_pkg::REG_EXP_COMMAND)
            cur_command = value;
        else
            cur_source = value;
    endtask

    task automatic set_config(input logic [sofdf_pkg::WORD_W-1:0] cmd,
                              input logic [sofdf_pkg::WORD_W-1:0] src);
        drain();
        write_reg(sofdf_pkg::REG_EXP_COMMAND, cmd);
        write_reg(sofdf_pkg::REG_EXP_SOURCE, src);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hard stop
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int r;
        int len;
        int n;
        sb = new();
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        frame_ch.ready = 1'b0;
        cur_command    = sofdf_pkg::CMD_RESET;
        cur_source     = sofdf_pkg::SRC_RESET;
        quiet          = 1'b0;
        rx_count       = 0;
        frame_bytes    = 0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: noise while hunting, short frames, every status
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, 1'b0, 1'b0, 1'b0);
        send_frame(2, 1'b0, 1'b0, 1'b0);
        send_frame(2, 1'b1, 1'b1, 1'b0);
        send_frame(1, 1'b0, 1'b1, 1'b1);

        // Random frames under four register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1: set_config(16'h0000, 16'hFFFF);
                2: set_config(16'hFFFF, 16'h0000);
                3: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                default: ;
            endcase
            if (ph == 1)
                send_frame(255, 1'b0, 1'b0, 1'b0);
            else if (ph == 2)
                send_frame(254, 1'b0, 1'b0, 1'b1);
            while (frame_bytes < BYTE_TARGET * (ph + 1) / 4)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    n = $urandom_range(0, 99);
                    if (n < 85)
                        len = $urandom_range(0, 12);
                    else if (n < 98)
                        len = $urandom_range(13, 60);
                    else
                        len = $urandom_range(200, 255);
                    send_frame(len, $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0,
                               $urandom_range(0, 6) == 0);
                end
                else if (r < 90)
                begin
                    // Line noise
                    n = $urandom_range(1, 4);
                    repeat (n) send_byte(8'($urandom_range(0, 255)));
                end
                else if (r < 97)
                begin
                    // Broken frame: start and length, then random tail
                    send_byte(sofdf_pkg::SOF_BYTE);
                    send_byte(8'($urandom_range(0, 15)));
                    n = $urandom_range(0, 6);
                    repeat (n) send_byte(8'($urandom_range(0, 255)));
                end
                else if (r < 99)
                    quiet = !quiet;
                else
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d bytes, checked %0d words over four register settings",
                 rx_count, sb.words_checked);
        $display("Frames closed: accepted %0d, check error %0d, command %0d, source %0d",
                 sb.status_count[sofdf_pkg::ST_ACCEPT], sb.status_count[sofdf_pkg::ST_CHECK],
                 sb.status_count[sofdf_pkg::ST_COMMAND],
                 sb.status_count[sofdf_pkg::ST_SOURCE]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
